// File: rtl/grid_bfs_shortest_path_core_macros.svh
// assertion macros shared by the core's modules
`ifndef GRID_BFS_SHORTEST_PATH_CORE_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define GBFS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GBFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define GBFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/gbfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbfs_pkg;

    // grid size
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int STEP_W = $clog2(CELLS);
    localparam int DIM_W  = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);

    // port field widths
    localparam int COORD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int DIST_W    = 13;
    localparam int EPOCH_W   = 4;

    localparam int DIST_SAT = 4095;

    localparam logic [CFG_W-1:0]         ROWS_RESET   = 7'd64;
    localparam logic [CFG_W-1:0]         COLS_RESET   = 7'd64;
    localparam logic signed [DIST_W-1:0] DIST_UNREACH = -13'sd1;

    // command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_LEFT,
        DIR_DOWN,
        DIR_UP
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CLEAR,
        S_SEED,
        S_POP,
        S_PROBE,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_UNREACH,
        RES_FOUND
    } t_res_sel;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [STEP_W-1:0] steps;
    } t_qent;

    typedef struct packed {
        logic               command;
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               cell_open;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] dst_row;
        logic [COORD_W-1:0] dst_col;
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     clr_start;
        logic     clr_step;
        logic     seed;
        logic     pop;
        logic     probe;
        logic     next_dir;
        logic     visit;
        logic     set_res;
        t_res_sel res_sel;
        logic     emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic search_cmd;
        logic same_pt;
        logic src_out;
        logic need_clear;
        logic clear_last;
        logic q_empty;
        logic nbr_in;
        logic dir_last;
        logic nbr_ok;
        logic nbr_is_dst;
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: rtl/gbfs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbfs_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [gbfs_pkg::COORD_W-1:0] cell_row;
    logic [gbfs_pkg::COORD_W-1:0] cell_col;
    logic                        cell_open;
    logic [gbfs_pkg::COORD_W-1:0] src_row;
    logic [gbfs_pkg::COORD_W-1:0] src_col;
    logic [gbfs_pkg::COORD_W-1:0] dst_row;
    logic [gbfs_pkg::COORD_W-1:0] dst_col;

    modport source (
        output valid, command, cell_row, cell_col, cell_open,
               src_row, src_col, dst_row, dst_col,
        input  ready
    );

    modport sink (
        input  valid, command, cell_row, cell_col, cell_open,
               src_row, src_col, dst_row, dst_col,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/gbfs_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gbfs_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [gbfs_pkg::DIST_W-1:0] distance;

    modport source (
        output valid, distance,
        input  ready
    );

    modport sink (
        input  valid, distance,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/gbfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// simple dual port ram, registered read
module gbfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gbfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bfs_shortest_path_core_macros.svh"

module gbfs_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [gbfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [gbfs_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire gbfs_pkg::t_req                   i_req,
    input  wire gbfs_pkg::t_dp_cmd                i_ctl,
    output gbfs_pkg::t_dp_sts                     o_sts,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [gbfs_pkg::DIST_W-1:0]    o_out_dist
);

    function automatic logic [gbfs_pkg::ADDR_W-1:0] cell_addr(
        input logic [gbfs_pkg::ROW_W-1:0] row,
        input logic [gbfs_pkg::COL_W-1:0] col
    );
        return gbfs_pkg::ADDR_W'(int'(row) * gbfs_pkg::MAX_COLS + int'(col));
    endfunction

    // configuration
    logic [gbfs_pkg::CFG_W-1:0] r_rows;
    logic [gbfs_pkg::CFG_W-1:0] r_cols;
    logic [gbfs_pkg::DIM_W-1:0] w_n;
    logic [gbfs_pkg::DIM_W-1:0] w_m;

    // search request
    logic [gbfs_pkg::COORD_W-1:0] r_sr;
    logic [gbfs_pkg::COORD_W-1:0] r_sc;
    logic [gbfs_pkg::COORD_W-1:0] r_dr;
    logic [gbfs_pkg::COORD_W-1:0] r_dc;

    // traversal state
    logic [gbfs_pkg::CNT_W-1:0]   r_head;
    logic [gbfs_pkg::CNT_W-1:0]   r_tail;
    logic [gbfs_pkg::EPOCH_W-1:0] r_epoch;
    logic [gbfs_pkg::EPOCH_W-1:0] w_epoch_next;
    logic [gbfs_pkg::ADDR_W-1:0]  r_clr;
    gbfs_pkg::t_dir               r_dir;
    logic [gbfs_pkg::ROW_W-1:0]   r_nrow;
    logic [gbfs_pkg::COL_W-1:0]   r_ncol;
    logic [gbfs_pkg::ROW_W-1:0]   w_nrow;
    logic [gbfs_pkg::COL_W-1:0]   w_ncol;
    logic                         w_nin;
    logic [gbfs_pkg::ADDR_W-1:0]  w_naddr;

    // result
    logic signed [gbfs_pkg::DIST_W-1:0] r_res;
    logic signed [gbfs_pkg::DIST_W-1:0] w_found_dist;
    logic [gbfs_pkg::STEP_W:0]          w_step1;
    logic                               r_out_valid;
    logic signed [gbfs_pkg::DIST_W-1:0] r_out_dist;

    // memories
    logic                                 w_grid_we;
    logic [gbfs_pkg::ADDR_W-1:0]          w_grid_waddr;
    logic [0:0]                           w_grid_rdata;
    logic                                 w_vis_we;
    logic [gbfs_pkg::ADDR_W-1:0]          w_vis_waddr;
    logic [gbfs_pkg::EPOCH_W-1:0]         w_vis_wdata;
    logic [gbfs_pkg::EPOCH_W-1:0]         w_vis_rdata;
    logic                                 w_q_we;
    logic [gbfs_pkg::ADDR_W-1:0]          w_q_waddr;
    gbfs_pkg::t_qent                      w_q_wdata;
    logic [$bits(gbfs_pkg::t_qent)-1:0]   w_q_rdata;
    gbfs_pkg::t_qent                      w_cur;
    logic                                 w_nbr_ok;
    logic                                 w_nbr_is_dst;
    logic                                 w_enqueue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= gbfs_pkg::ROWS_RESET;
            r_cols <= gbfs_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbfs_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                gbfs_pkg::CFG_COLS: r_cols <= i_cfg_data;
            endcase
        end
    end

    // area in use, out-of-range settings clamped
    always_comb begin
        if (r_rows == '0) begin
            w_n = gbfs_pkg::DIM_W'(1);
        end else if (int'(r_rows) > gbfs_pkg::MAX_ROWS) begin
            w_n = gbfs_pkg::DIM_W'(gbfs_pkg::MAX_ROWS);
        end else begin
            w_n = gbfs_pkg::DIM_W'(r_rows);
        end
        if (r_cols == '0) begin
            w_m = gbfs_pkg::DIM_W'(1);
        end else if (int'(r_cols) > gbfs_pkg::MAX_COLS) begin
            w_m = gbfs_pkg::DIM_W'(gbfs_pkg::MAX_COLS);
        end else begin
            w_m = gbfs_pkg::DIM_W'(r_cols);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_sr <= i_req.src_row;
            r_sc <= i_req.src_col;
            r_dr <= i_req.dst_row;
            r_dc <= i_req.dst_col;
        end
    end

    // grid store write from load transfers
    assign w_grid_we = i_ctl.accept && (i_req.command == gbfs_pkg::CMD_LOAD)
                    && (int'(i_req.cell_row) < gbfs_pkg::MAX_ROWS)
                    && (int'(i_req.cell_col) < gbfs_pkg::MAX_COLS);
    assign w_grid_waddr = cell_addr(gbfs_pkg::ROW_W'(i_req.cell_row),
                                    gbfs_pkg::COL_W'(i_req.cell_col));

    // current cell is held in the queue read register
    assign w_cur = gbfs_pkg::t_qent'(w_q_rdata);

    always_comb begin
        w_nrow = w_cur.row;
        w_ncol = w_cur.col;
        w_nin  = 1'b0;
        case (r_dir)
            gbfs_pkg::DIR_RIGHT: begin
                w_ncol = w_cur.col + 1'b1;
                w_nin  = (int'(w_cur.col) + 1) < int'(w_m);
            end
            gbfs_pkg::DIR_LEFT: begin
                w_ncol = w_cur.col - 1'b1;
                w_nin  = (w_cur.col != '0);
            end
            gbfs_pkg::DIR_DOWN: begin
                w_nrow = w_cur.row + 1'b1;
                w_nin  = (int'(w_cur.row) + 1) < int'(w_n);
            end
            gbfs_pkg::DIR_UP: begin
                w_nrow = w_cur.row - 1'b1;
                w_nin  = (w_cur.row != '0);
            end
        endcase
    end

    assign w_naddr = cell_addr(w_nrow, w_ncol);

    assign w_nbr_ok     = w_grid_rdata[0] && (w_vis_rdata != r_epoch);
    assign w_nbr_is_dst = (int'(r_nrow) == int'(r_dr)) && (int'(r_ncol) == int'(r_dc));
    assign w_enqueue    = i_ctl.visit && !w_nbr_is_dst
                       && (int'(r_tail) < gbfs_pkg::CELLS);

    // epoch mark: visited when stored tag equals the current epoch
    assign w_epoch_next = (r_epoch == '1) ? gbfs_pkg::EPOCH_W'(1) : (r_epoch + 1'b1);

    always_comb begin
        w_vis_we    = i_ctl.clr_step || i_ctl.seed || i_ctl.visit;
        w_vis_waddr = cell_addr(r_nrow, r_ncol);
        w_vis_wdata = r_epoch;
        if (i_ctl.clr_step) begin
            w_vis_waddr = r_clr;
            w_vis_wdata = '0;
        end else if (i_ctl.seed) begin
            w_vis_waddr = cell_addr(gbfs_pkg::ROW_W'(r_sr), gbfs_pkg::COL_W'(r_sc));
            w_vis_wdata = w_epoch_next;
        end
    end

    always_comb begin
        w_q_we    = i_ctl.seed || w_enqueue;
        w_q_waddr = r_tail[gbfs_pkg::ADDR_W-1:0];
        w_q_wdata = '{row: r_nrow, col: r_ncol,
                      steps: gbfs_pkg::STEP_W'(w_step1)};
        if (i_ctl.seed) begin
            w_q_waddr = '0;
            w_q_wdata = '{row: gbfs_pkg::ROW_W'(r_sr), col: gbfs_pkg::COL_W'(r_sc),
                          steps: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_epoch <= '1;
            r_clr   <= '0;
            r_dir   <= gbfs_pkg::DIR_RIGHT;
        end else begin
            if (i_ctl.clr_start) begin
                r_clr <= '0;
            end else if (i_ctl.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_ctl.seed) begin
                r_head  <= '0;
                r_tail  <= gbfs_pkg::CNT_W'(1);
                r_epoch <= w_epoch_next;
            end else begin
                if (i_ctl.pop) begin
                    r_head <= r_head + 1'b1;
                end
                if (w_enqueue) begin
                    r_tail <= r_tail + 1'b1;
                end
            end
            if (i_ctl.pop) begin
                r_dir <= gbfs_pkg::DIR_RIGHT;
            end else if (i_ctl.next_dir) begin
                r_dir <= gbfs_pkg::t_dir'(2'(r_dir) + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.probe) begin
            r_nrow <= w_nrow;
            r_ncol <= w_ncol;
        end
    end

    // step count of the neighbour just reached, saturated
    assign w_step1      = {1'b0, w_cur.steps} + 1'b1;
    assign w_found_dist = (int'(w_step1) > gbfs_pkg::DIST_SAT)
                        ? gbfs_pkg::DIST_W'(gbfs_pkg::DIST_SAT)
                        : gbfs_pkg::DIST_W'(w_step1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.set_res) begin
            case (i_ctl.res_sel)
                gbfs_pkg::RES_ZERO:    r_res <= '0;
                gbfs_pkg::RES_UNREACH: r_res <= gbfs_pkg::DIST_UNREACH;
                gbfs_pkg::RES_FOUND:   r_res <= w_found_dist;
                default:               r_res <= gbfs_pkg::DIST_UNREACH;
            endcase
        end
        if (i_ctl.emit) begin
            r_out_dist <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_dist  = r_out_dist;

    gbfs_ram #(.WIDTH(1), .DEPTH(gbfs_pkg::CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_grid_we),
        .i_waddr (w_grid_waddr),
        .i_wdata (i_req.cell_open),
        .i_re    (i_ctl.probe),
        .i_raddr (w_naddr),
        .o_rdata (w_grid_rdata)
    );

    gbfs_ram #(.WIDTH(gbfs_pkg::EPOCH_W), .DEPTH(gbfs_pkg::CELLS)) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_re    (i_ctl.probe),
        .i_raddr (w_naddr),
        .o_rdata (w_vis_rdata)
    );

    gbfs_ram #(.WIDTH($bits(gbfs_pkg::t_qent)), .DEPTH(gbfs_pkg::CELLS)) u_queue (
        .i_clk   (i_clk),
        .i_we    (w_q_we),
        .i_waddr (w_q_waddr),
        .i_wdata (w_q_wdata),
        .i_re    (i_ctl.pop),
        .i_raddr (r_head[gbfs_pkg::ADDR_W-1:0]),
        .o_rdata (w_q_rdata)
    );

    assign o_sts.search_cmd = (i_req.command == gbfs_pkg::CMD_SEARCH);
    assign o_sts.same_pt    = (r_sr == r_dr) && (r_sc == r_dc);
    assign o_sts.src_out    = (int'(r_sr) >= int'(w_n)) || (int'(r_sc) >= int'(w_m));
    assign o_sts.need_clear = (r_epoch == '1);
    assign o_sts.clear_last = (r_clr == gbfs_pkg::ADDR_W'(gbfs_pkg::CELLS - 1));
    assign o_sts.q_empty    = !((r_head < r_tail) && (int'(r_head) < gbfs_pkg::CELLS));
    assign o_sts.nbr_in     = w_nin;
    assign o_sts.dir_last   = (r_dir == gbfs_pkg::DIR_UP);
    assign o_sts.nbr_ok     = w_nbr_ok;
    assign o_sts.nbr_is_dst = w_nbr_is_dst;
    assign o_sts.out_full   = r_out_valid;

    `GBFS_ASSERT_ALWAYS(a_head_le_tail, i_clk, i_rst_n, r_head <= r_tail, "queue head passed tail")
    `GBFS_ASSERT_IMPL(a_emit_free, i_clk, i_rst_n, i_ctl.emit, !r_out_valid, "result overwritten")
    `GBFS_ASSERT_IMPL(a_visit_ok, i_clk, i_rst_n, i_ctl.visit, w_nbr_ok, "visit of rejected cell")

endmodule

`default_nettype wire

// File: rtl/gbfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bfs_shortest_path_core_macros.svh"

module gbfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gbfs_pkg::t_dp_sts i_sts,
    output gbfs_pkg::t_dp_cmd      o_cmd
);

    gbfs_pkg::t_state r_state;
    gbfs_pkg::t_state n_state;
    logic             w_accept;

    assign o_in_ready = (r_state == gbfs_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbfs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbfs_pkg::S_IDLE: begin
                if (w_accept && i_sts.search_cmd) begin
                    n_state = gbfs_pkg::S_START;
                end
            end
            gbfs_pkg::S_START: begin
                if (i_sts.same_pt || i_sts.src_out) begin
                    n_state = gbfs_pkg::S_EMIT;
                end else if (i_sts.need_clear) begin
                    n_state = gbfs_pkg::S_CLEAR;
                end else begin
                    n_state = gbfs_pkg::S_SEED;
                end
            end
            gbfs_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = gbfs_pkg::S_SEED;
                end
            end
            gbfs_pkg::S_SEED: n_state = gbfs_pkg::S_POP;
            gbfs_pkg::S_POP: begin
                n_state = i_sts.q_empty ? gbfs_pkg::S_EMIT : gbfs_pkg::S_PROBE;
            end
            gbfs_pkg::S_PROBE: begin
                if (i_sts.nbr_in) begin
                    n_state = gbfs_pkg::S_CHECK;
                end else if (i_sts.dir_last) begin
                    n_state = gbfs_pkg::S_POP;
                end
            end
            gbfs_pkg::S_CHECK: begin
                if (i_sts.nbr_ok && i_sts.nbr_is_dst) begin
                    n_state = gbfs_pkg::S_EMIT;
                end else if (i_sts.dir_last) begin
                    n_state = gbfs_pkg::S_POP;
                end else begin
                    n_state = gbfs_pkg::S_PROBE;
                end
            end
            gbfs_pkg::S_EMIT: begin
                if (!i_sts.out_full) begin
                    n_state = gbfs_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        unique case (r_state)
            gbfs_pkg::S_IDLE: begin
            end
            gbfs_pkg::S_START: begin
                if (i_sts.same_pt) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = gbfs_pkg::RES_ZERO;
                end else if (i_sts.src_out) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = gbfs_pkg::RES_UNREACH;
                end else if (i_sts.need_clear) begin
                    o_cmd.clr_start = 1'b1;
                end
            end
            gbfs_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            gbfs_pkg::S_SEED:  o_cmd.seed = 1'b1;
            gbfs_pkg::S_POP: begin
                if (i_sts.q_empty) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = gbfs_pkg::RES_UNREACH;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            gbfs_pkg::S_PROBE: begin
                if (i_sts.nbr_in) begin
                    o_cmd.probe = 1'b1;
                end else if (!i_sts.dir_last) begin
                    o_cmd.next_dir = 1'b1;
                end
            end
            gbfs_pkg::S_CHECK: begin
                o_cmd.visit = i_sts.nbr_ok;
                if (i_sts.nbr_ok && i_sts.nbr_is_dst) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = gbfs_pkg::RES_FOUND;
                end else if (!i_sts.dir_last) begin
                    o_cmd.next_dir = 1'b1;
                end
            end
            gbfs_pkg::S_EMIT: o_cmd.emit = !i_sts.out_full;
        endcase
    end

    `GBFS_ASSERT_NEXT(a_probe_check, i_clk, i_rst_n, (r_state == gbfs_pkg::S_PROBE) && i_sts.nbr_in, r_state == gbfs_pkg::S_CHECK, "probe not followed by check")
    `GBFS_ASSERT_NEXT(a_clear_runs, i_clk, i_rst_n, (r_state == gbfs_pkg::S_CLEAR) && !i_sts.clear_last, r_state == gbfs_pkg::S_CLEAR, "clearing pass cut short")

endmodule

`default_nettype wire

// File: rtl/grid_bfs_shortest_path_core.sv
// Shortest-path engine on a binary grid with four-neighbour moves. A load transfer
// (command 0) writes one cell (open or blocked) into the grid store and gives no
// result; loads outside the store are dropped. A search transfer (command 1) runs a
// breadth-first search from the source and returns one distance: 0 when source and
// destination coincide, the saturated step count (at most 4095) when reached, and
// -1 when unreachable, when the source lies outside the area in use, or when the
// destination does. Neighbours are tried right, left, down, up. The block works on one
// search at a time: after setup it dequeues cells one by one, probes each in-bounds
// neighbour through the single read port of the grid and visited memories, checks it
// and skips out-of-bounds directions without a probe. The visited map is tagged with
// a 4-bit search epoch that only searches which reach the traversal use; the first
// such search after reset and every 15th one after that start with a clearing pass
// over all 4096 entries (one entry a cycle) before the traversal. Searches settled at
// once (coincident endpoints, source outside the area) skip both. Grid cells read by a
// search must have been loaded since reset. The finished distance waits in an output
// register, so loads and the next search are taken while a result is still pending.
// The user must write rows_in_use and cols_in_use only while the block is idle; the
// block does not enforce it. 0 acts as 1 and values above the grid size are clamped.
`timescale 1ns / 1ps
`default_nettype none

module grid_bfs_shortest_path_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    gbfs_req_if.sink                            i_req,
    gbfs_rsp_if.source                          o_rsp,
    input  wire logic                           i_cfg_we,
    input  wire logic [gbfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [gbfs_pkg::CFG_W-1:0]     i_cfg_data
);

    // request payload bundled for the datapath
    gbfs_pkg::t_req    w_req;
    // controller commands and datapath status
    gbfs_pkg::t_dp_cmd w_cmd;
    gbfs_pkg::t_dp_sts w_sts;
    logic              w_in_ready;
    logic              w_out_valid;
    logic signed [gbfs_pkg::DIST_W-1:0] w_out_dist;

    assign w_req = '{
        command:   i_req.command,
        cell_row:  i_req.cell_row,
        cell_col:  i_req.cell_col,
        cell_open: i_req.cell_open,
        src_row:   i_req.src_row,
        src_col:   i_req.src_col,
        dst_row:   i_req.dst_row,
        dst_col:   i_req.dst_col
    };

    // input transfers are taken only while the controller is idle
    assign i_req.ready = w_in_ready;

    // result register drives the output channel directly
    assign o_rsp.valid    = w_out_valid;
    assign o_rsp.distance = w_out_dist;

    // sequencer: clearing pass, seeding, dequeue and the four neighbour probes
    gbfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // grid store, visited map, frontier queue, configuration and result register
    gbfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req       (w_req),
        .i_ctl       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (w_out_valid),
        .o_out_dist  (w_out_dist)
    );

endmodule

`default_nettype wire
